@@ hdl/dtmft_pkg.sv @@
// Package for the detection to map frame transform.
// Holds the widths, constants, status codes and stage record types.
// Used by every module of the block; depends on nothing.
package dtmft_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int GUARD            = 6;
  localparam int SHW              = $clog2(ANGLE_ITERATIONS);
  localparam int NSTAGE           = ANGLE_ITERATIONS + 4;

  // vector state, point state, translated point and scaling product widths
  localparam int CW = 38;
  localparam int PW = 40;
  localparam int SW = 42;
  localparam int MW = 50;

  localparam logic [63:0] INVK_Q30 = 64'd652032874;
  localparam logic [63:0] INVK_FULL =
    INVK_Q30 + ((INVK_Q30 * 64'd2 / 64'd3) >> (2 * ANGLE_ITERATIONS));
  localparam logic signed [31:0] INVK = 32'(INVK_FULL);

  localparam logic signed [CW-1:0] C_ONE_Q28 = CW'(64'sd268435456);
  localparam logic signed [MW-1:0] CM_SCALE  = MW'(64'sd100);
  localparam logic signed [MW-1:0] CM_HALF   = MW'(64'sd2097152);
  localparam logic signed [MW-1:0] SAT_MAX   = MW'(64'sd8388607);
  localparam logic signed [MW-1:0] SAT_MIN   = MW'(-64'sd8388608);

  localparam logic [7:0] CLS_NONE     = 8'd0;
  localparam logic [7:0] CLS_HERO     = 8'd1;
  localparam logic [7:0] CLS_ENGINEER = 8'd2;
  localparam logic [7:0] CLS_INF3     = 8'd3;
  localparam logic [7:0] CLS_INF4     = 8'd4;
  localparam logic [7:0] CLS_SENTRY   = 8'd7;

  typedef enum logic [2:0] {
    SLOT_HERO     = 3'd0,
    SLOT_ENGINEER = 3'd1,
    SLOT_INF3     = 3'd2,
    SLOT_INF4     = 3'd3,
    SLOT_SENTRY   = 3'd4
  } slot_e;

  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_REJECT  = 2'd1,
    ST_NO_POSE = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]              status;
    logic [2:0]              slot;
    logic                    degen;
    logic signed [31:0]      tx;
    logic signed [31:0]      ty;
    logic signed [CW-1:0]    c;
    logic signed [CW-1:0]    s;
    logic signed [PW-1:0]    px;
    logic signed [PW-1:0]    py;
  } cor_t;

endpackage

@@ hdl/dtmft_front.sv @@
// Front end: quaternion products, gain multiply, yaw vector and pre-rotation.
// Two register stages; uses dtmft_pkg.
module dtmft_front (
  input  logic                     clk_i,
  input  logic [1:0]               en_i,
  input  logic [7:0]               target_class_i,
  input  logic signed [31:0]       body_x_i,
  input  logic signed [31:0]       body_y_i,
  input  logic signed [31:0]       pose_x_i,
  input  logic signed [31:0]       pose_y_i,
  input  logic signed [15:0]       quat_w_i,
  input  logic signed [15:0]       quat_x_i,
  input  logic signed [15:0]       quat_y_i,
  input  logic signed [15:0]       quat_z_i,
  input  logic                     pose_ok_i,
  output dtmft_pkg::cor_t          cor_o
);

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         slot;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] pwz;
    logic signed [31:0] pxy;
    logic signed [31:0] pyy;
    logic signed [31:0] pzz;
    logic signed [63:0] mx;
    logic signed [63:0] my;
  } front_t;

  front_t a_d, a_q;
  dtmft_pkg::cor_t b_d, b_q;

  logic signed [31:0] w32, x32, y32, z32;

  always_comb begin
    w32 = 32'(quat_w_i);
    x32 = 32'(quat_x_i);
    y32 = 32'(quat_y_i);
    z32 = 32'(quat_z_i);
    a_d.status = dtmft_pkg::ST_UPDATED;
    a_d.slot   = dtmft_pkg::SLOT_HERO;
    if (target_class_i == dtmft_pkg::CLS_NONE || body_x_i == 32'sd0 ||
        body_y_i == 32'sd0) begin
      a_d.status = dtmft_pkg::ST_REJECT;
    end else if (!pose_ok_i) begin
      a_d.status = dtmft_pkg::ST_NO_POSE;
    end else begin
      case (target_class_i)
        dtmft_pkg::CLS_HERO:     a_d.slot = dtmft_pkg::SLOT_HERO;
        dtmft_pkg::CLS_ENGINEER: a_d.slot = dtmft_pkg::SLOT_ENGINEER;
        dtmft_pkg::CLS_INF3:     a_d.slot = dtmft_pkg::SLOT_INF3;
        dtmft_pkg::CLS_INF4:     a_d.slot = dtmft_pkg::SLOT_INF4;
        dtmft_pkg::CLS_SENTRY:   a_d.slot = dtmft_pkg::SLOT_SENTRY;
        default:                 a_d.status = dtmft_pkg::ST_UNKNOWN;
      endcase
    end
    a_d.tx  = pose_x_i;
    a_d.ty  = pose_y_i;
    a_d.bx  = body_x_i;
    a_d.by  = body_y_i;
    a_d.pwz = w32 * z32;
    a_d.pxy = x32 * y32;
    a_d.pyy = y32 * y32;
    a_d.pzz = z32 * z32;
    a_d.mx  = 64'(body_x_i) * 64'(dtmft_pkg::INVK);
    a_d.my  = 64'(body_y_i) * 64'(dtmft_pkg::INVK);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_q <= a_d;
    end
  end

  logic signed [dtmft_pkg::CW-1:0] s_v, c_v;
  logic signed [dtmft_pkg::PW-1:0] px_v, py_v;
  logic                            degen;

  always_comb begin
    s_v = (dtmft_pkg::CW'(a_q.pwz) + dtmft_pkg::CW'(a_q.pxy)) <<< 1;
    c_v = dtmft_pkg::C_ONE_Q28 -
          ((dtmft_pkg::CW'(a_q.pyy) + dtmft_pkg::CW'(a_q.pzz)) <<< 1);
    degen = (s_v == '0) && (c_v == '0);
    if (degen) begin
      px_v = dtmft_pkg::PW'(a_q.bx) <<< dtmft_pkg::GUARD;
      py_v = dtmft_pkg::PW'(a_q.by) <<< dtmft_pkg::GUARD;
    end else begin
      px_v = dtmft_pkg::PW'(a_q.mx >>> (30 - dtmft_pkg::GUARD));
      py_v = dtmft_pkg::PW'(a_q.my >>> (30 - dtmft_pkg::GUARD));
    end
    b_d.status = a_q.status;
    b_d.slot   = a_q.slot;
    b_d.degen  = degen;
    b_d.tx     = a_q.tx;
    b_d.ty     = a_q.ty;
    b_d.c      = c_v;
    b_d.s      = s_v;
    b_d.px     = px_v;
    b_d.py     = py_v;
    // turn a left half-plane vector by a quarter turn first
    if (!degen && c_v < 0) begin
      if (s_v >= 0) begin
        b_d.c  = s_v;
        b_d.s  = -c_v;
        b_d.px = -py_v;
        b_d.py = px_v;
      end else begin
        b_d.c  = -s_v;
        b_d.s  = c_v;
        b_d.px = py_v;
        b_d.py = -px_v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      b_q <= b_d;
    end
  end

  assign cor_o = b_q;

endmodule

@@ hdl/dtmft_cordic_stage.sv @@
// One CORDIC micro-rotation: vectoring on (c, s), rotating the point along.
// Uses dtmft_pkg for the stage record.
module dtmft_cordic_stage (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [dtmft_pkg::SHW-1:0]     sh_i,
  input  dtmft_pkg::cor_t               cor_i,
  output dtmft_pkg::cor_t               cor_o
);

  dtmft_pkg::cor_t cor_d, cor_q;

  always_comb begin
    cor_d = cor_i;
    if (!cor_i.degen) begin
      if (cor_i.s >= 0) begin
        cor_d.c  = cor_i.c + (cor_i.s >>> sh_i);
        cor_d.s  = cor_i.s - (cor_i.c >>> sh_i);
        cor_d.px = cor_i.px - (cor_i.py >>> sh_i);
        cor_d.py = cor_i.py + (cor_i.px >>> sh_i);
      end else begin
        cor_d.c  = cor_i.c - (cor_i.s >>> sh_i);
        cor_d.s  = cor_i.s + (cor_i.c >>> sh_i);
        cor_d.px = cor_i.px + (cor_i.py >>> sh_i);
        cor_d.py = cor_i.py - (cor_i.px >>> sh_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cor_q <= cor_d;
    end
  end

  assign cor_o = cor_q;

endmodule

@@ hdl/dtmft_back.sv @@
// Back end: add translation, scale to centimetres, round, saturate, mask.
// Two register stages; uses dtmft_pkg.
module dtmft_back (
  input  logic                 clk_i,
  input  logic [1:0]           en_i,
  input  dtmft_pkg::cor_t      cor_i,
  output logic [1:0]           status_o,
  output logic [2:0]           slot_o,
  output logic signed [23:0]   map_x_cm_o,
  output logic signed [23:0]   map_y_cm_o
);

  logic [1:0]                      st_q;
  logic [2:0]                      sl_q;
  logic signed [dtmft_pkg::SW-1:0] sx_q, sy_q, sx_d, sy_d;

  assign sx_d = (dtmft_pkg::SW'(cor_i.tx) <<< dtmft_pkg::GUARD) + dtmft_pkg::SW'(cor_i.px);
  assign sy_d = (dtmft_pkg::SW'(cor_i.ty) <<< dtmft_pkg::GUARD) + dtmft_pkg::SW'(cor_i.py);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      st_q <= cor_i.status;
      sl_q <= cor_i.slot;
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
  end

  function automatic logic signed [23:0] to_cm(input logic signed [dtmft_pkg::SW-1:0] v);
    logic signed [dtmft_pkg::MW-1:0] m;
    logic signed [dtmft_pkg::MW-1:0] r;
    begin
      m = dtmft_pkg::MW'(v) * dtmft_pkg::CM_SCALE + dtmft_pkg::CM_HALF;
      r = m >>> (dtmft_pkg::GUARD + 16);
      if (r > dtmft_pkg::SAT_MAX) r = dtmft_pkg::SAT_MAX;
      if (r < dtmft_pkg::SAT_MIN) r = dtmft_pkg::SAT_MIN;
      to_cm = r[23:0];
    end
  endfunction

  logic upd;
  assign upd = (st_q == dtmft_pkg::ST_UPDATED);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      status_o   <= st_q;
      slot_o     <= upd ? sl_q : 3'd0;
      map_x_cm_o <= upd ? to_cm(sx_q) : 24'sd0;
      map_y_cm_o <= upd ? to_cm(sy_q) : 24'sd0;
    end
  end

endmodule

@@ hdl/detection_to_map_frame_transform.sv @@
// Detection to map frame transform, top level.
// Requests pass through dtmft_front, the chain of CORDIC stages and dtmft_back to the result.
// Throughput: one request per cycle while out_stall_i is low; each stage moves on when the next one frees up.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; payload is not reset.
// Uses dtmft_pkg, dtmft_front, dtmft_cordic_stage and dtmft_back.
module detection_to_map_frame_transform (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          target_class_i,
  input  logic signed [31:0]  body_x_i,
  input  logic signed [31:0]  body_y_i,
  input  logic signed [31:0]  pose_x_i,
  input  logic signed [31:0]  pose_y_i,
  input  logic signed [15:0]  quat_w_i,
  input  logic signed [15:0]  quat_x_i,
  input  logic signed [15:0]  quat_y_i,
  input  logic signed [15:0]  quat_z_i,
  input  logic                pose_ok_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [2:0]          slot_o,
  output logic signed [23:0]  map_x_cm_o,
  output logic signed [23:0]  map_y_cm_o
);

  localparam int N = dtmft_pkg::NSTAGE;

  logic [N-1:0] vld_q, vld_d, rdy;

  always_comb begin
    rdy[N-1] = !vld_q[N-1] || !out_stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = in_valid_i;
    for (int k = 1; k < N; k++) begin
      vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) vld_q[k] <= vld_d[k];
      end
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[N-1];

  dtmft_pkg::cor_t cor_w [dtmft_pkg::ANGLE_ITERATIONS+1];

  dtmft_front u_front (
    .clk_i          (clk_i),
    .en_i           (rdy[1:0]),
    .target_class_i (target_class_i),
    .body_x_i       (body_x_i),
    .body_y_i       (body_y_i),
    .pose_x_i       (pose_x_i),
    .pose_y_i       (pose_y_i),
    .quat_w_i       (quat_w_i),
    .quat_x_i       (quat_x_i),
    .quat_y_i       (quat_y_i),
    .quat_z_i       (quat_z_i),
    .pose_ok_i      (pose_ok_i),
    .cor_o          (cor_w[0])
  );

  for (genvar i = 0; i < dtmft_pkg::ANGLE_ITERATIONS; i++) begin : g_cordic
    dtmft_cordic_stage u_stage (
      .clk_i (clk_i),
      .en_i  (rdy[i+2]),
      .sh_i  (dtmft_pkg::SHW'(i)),
      .cor_i (cor_w[i]),
      .cor_o (cor_w[i+1])
    );
  end

  dtmft_back u_back (
    .clk_i      (clk_i),
    .en_i       (rdy[N-1:N-2]),
    .cor_i      (cor_w[dtmft_pkg::ANGLE_ITERATIONS]),
    .status_o   (status_o),
    .slot_o     (slot_o),
    .map_x_cm_o (map_x_cm_o),
    .map_y_cm_o (map_y_cm_o)
  );

endmodule
